>>> rtl/iir_df1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I package
// Shared widths, types and constants for the direct form I IIR filter.
// ----------------------------------------------------------------------------
package iir_df1_pkg;

  localparam int SampleW  = 16;           // Q1.15 samples
  localparam int CoefW    = 20;           // Q4.16 coefficients
  localparam int FracW    = 16;           // coefficient fraction bits
  localparam int CfgIdxW  = 5;            // register index field of the config port
  localparam int CfgDataW = CoefW;

  localparam int OutMax    = 32767;
  localparam int OutMin    = -32768;
  localparam int RoundHalf = 32768;       // half an output LSB at Q5.31
  localparam int CoefUnity = 65536;       // 1.0 in Q4.16

  typedef logic signed [SampleW-1:0]  sample_t;
  typedef logic signed [CoefW-1:0]    coef_t;
  typedef logic        [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic        [CfgDataW-1:0] cfg_data_t;

endpackage

>>> rtl/iir_df1_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I stream interfaces
// Valid/ready channels for input samples and filtered result samples.
// ----------------------------------------------------------------------------
interface iir_df1_in_if;
  logic                 valid;
  logic                 ready;
  iir_df1_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df1_out_if;
  logic                 valid;
  logic                 ready;
  iir_df1_pkg::sample_t sample_out;
  logic                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

>>> rtl/iir_df1_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I coefficient registers
// Feedforward and feedback coefficient bank written through the config port.
// ----------------------------------------------------------------------------
module iir_df1_coef_regs #(
  parameter int FF_ORDER = 2,
  parameter int FB_ORDER = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  iir_df1_pkg::cfg_idx_t  cfg_idx_i,
  input  iir_df1_pkg::cfg_data_t cfg_data_i,
  output iir_df1_pkg::coef_t     ff_coef_o [FF_ORDER+1],
  output iir_df1_pkg::coef_t     fb_coef_o [FB_ORDER]
);
  import iir_df1_pkg::*;

  coef_t ff_coef_q [FF_ORDER+1];
  coef_t fb_coef_q [FB_ORDER];

  // b[0] resets to unity so the filter passes samples straight through
  for (genvar k = 0; k <= FF_ORDER; k++) begin : g_ff
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ff_coef_q[k] <= (k == 0) ? CoefW'(CoefUnity) : '0;
      end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(k))) begin
        ff_coef_q[k] <= coef_t'(cfg_data_i);
      end
    end
    assign ff_coef_o[k] = ff_coef_q[k];
  end

  // fb_coef_o[k] holds a[k+1]
  for (genvar k = 0; k < FB_ORDER; k++) begin : g_fb
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fb_coef_q[k] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(FF_ORDER + 1 + k))) begin
        fb_coef_q[k] <= coef_t'(cfg_data_i);
      end
    end
    assign fb_coef_o[k] = fb_coef_q[k];
  end

endmodule

>>> rtl/iir_df1_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I multiply-accumulate
// Parallel tap products, sum, round half up to Q1.15 and saturate.
// ----------------------------------------------------------------------------
module iir_df1_mac #(
  parameter int FF_ORDER = 2,
  parameter int FB_ORDER = 2
) (
  input  iir_df1_pkg::sample_t x_i,
  input  iir_df1_pkg::sample_t xh_i      [FF_ORDER],
  input  iir_df1_pkg::sample_t yh_i      [FB_ORDER],
  input  iir_df1_pkg::coef_t   ff_coef_i [FF_ORDER+1],
  input  iir_df1_pkg::coef_t   fb_coef_i [FB_ORDER],
  output iir_df1_pkg::sample_t y_o,
  output logic                 clip_o
);
  import iir_df1_pkg::*;

  localparam int ProdW = SampleW + CoefW;
  localparam int AccW  = ProdW + $clog2(FF_ORDER + FB_ORDER + 1);
  localparam int RndW  = AccW - FracW;
  localparam logic signed [RndW-1:0] RndMax = RndW'(OutMax);
  localparam logic signed [RndW-1:0] RndMin = RndW'(OutMin);

  logic signed [ProdW-1:0] prod_ff [FF_ORDER+1];
  logic signed [ProdW-1:0] prod_fb [FB_ORDER];
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [RndW-1:0]  rnd;

  // independent tap products
  always_comb begin
    prod_ff[0] = ff_coef_i[0] * x_i;
    for (int k = 1; k <= FF_ORDER; k++) begin
      prod_ff[k] = ff_coef_i[k] * xh_i[k-1];
    end
    for (int k = 0; k < FB_ORDER; k++) begin
      prod_fb[k] = fb_coef_i[k] * yh_i[k];
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k <= FF_ORDER; k++) begin
      acc = acc + AccW'(prod_ff[k]);
    end
    for (int k = 0; k < FB_ORDER; k++) begin
      acc = acc - AccW'(prod_fb[k]);
    end
    acc_rnd = acc + AccW'(RoundHalf);
    rnd     = $signed(acc_rnd[AccW-1:FracW]);
  end

  always_comb begin
    clip_o = 1'b0;
    y_o    = sample_t'(rnd[SampleW-1:0]);
    if (rnd > RndMax) begin
      clip_o = 1'b1;
      y_o    = sample_t'(OutMax);
    end else if (rnd < RndMin) begin
      clip_o = 1'b1;
      y_o    = sample_t'(OutMin);
    end
  end

endmodule

>>> rtl/iir_filter_direct_form_one.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct form I IIR filter
// Fixed-point IIR filter with Q4.16 coefficients and Q1.15 samples.
// ----------------------------------------------------------------------------
// The filter computes y[n] = sum b[k]*x[n-k] (k = 0..FF_ORDER) minus
// sum a[k]*y[n-k] (k = 1..FB_ORDER), rounds half up to Q1.15 and saturates,
// raising clipped on saturation; the saturated value is what feeds back.
// Throughput is one sample per clock while the output is not stalled: a
// sample is captured in the input register, and once the result register
// is free all tap products, the sum, the rounding and the saturation
// resolve in one pass into the result register while the delay lines shift.
// The result passes the input register, then the result register; a stalled
// result register holds the input register, so at most two samples are in
// flight. The feedback loop closes inside that single compute stage, so the
// parallel multipliers and the adder tree set the clock rate. Coefficients
// are registers b[0..FF_ORDER] at indices 0..FF_ORDER, then a[1..FB_ORDER]
// at the following indices; writes to other indices are dropped. Write them
// only while the filter is idle. Reset sets b[0] to 1.0, every other
// coefficient and both delay lines to zero.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one #(
  parameter int FF_ORDER = 2,   // 1..8
  parameter int FB_ORDER = 2    // 1..8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  iir_df1_pkg::cfg_idx_t  cfg_idx_i,
  input  iir_df1_pkg::cfg_data_t cfg_data_i,
  iir_df1_in_if.sink             in_i,
  iir_df1_out_if.source          out_o
);
  import iir_df1_pkg::*;

  // coefficient bank
  coef_t ff_coef [FF_ORDER+1];
  coef_t fb_coef [FB_ORDER];

  iir_df1_coef_regs #(
    .FF_ORDER (FF_ORDER),
    .FB_ORDER (FB_ORDER)
  ) u_coef_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ff_coef_o  (ff_coef),
    .fb_coef_o  (fb_coef)
  );

  // input register
  logic    x_valid_q;
  sample_t x_q;

  // delay lines: xh_q[k] is x[n-1-k], yh_q[k] is y[n-1-k]
  sample_t xh_q [FF_ORDER];
  sample_t yh_q [FB_ORDER];

  // result register
  logic    out_valid_q;
  sample_t sample_out_q;
  logic    clipped_q;

  sample_t y;
  logic    clip;
  logic    fire;
  logic    in_ready;

  // Compute when a sample is held and the result register is free or
  // being emptied in this cycle.
  assign fire     = x_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !x_valid_q || fire;

  assign in_i.ready = in_ready;

  iir_df1_mac #(
    .FF_ORDER (FF_ORDER),
    .FB_ORDER (FB_ORDER)
  ) u_mac (
    .x_i       (x_q),
    .xh_i      (xh_q),
    .yh_i      (yh_q),
    .ff_coef_i (ff_coef),
    .fb_coef_i (fb_coef),
    .y_o       (y),
    .clip_o    (clip)
  );

  // Hold the input sample until it is computed; take a new one on the
  // same edge the current one fires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else if (in_ready) begin
      x_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      x_q <= in_i.sample_in;
    end
  end

  // Advance both delay lines with each computed sample. The output line
  // takes the saturated result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FF_ORDER; k++) begin
        xh_q[k] <= '0;
      end
      for (int k = 0; k < FB_ORDER; k++) begin
        yh_q[k] <= '0;
      end
    end else if (fire) begin
      for (int k = 1; k < FF_ORDER; k++) begin
        xh_q[k] <= xh_q[k-1];
      end
      xh_q[0] <= x_q;
      for (int k = 1; k < FB_ORDER; k++) begin
        yh_q[k] <= yh_q[k-1];
      end
      yh_q[0] <= y;
    end
  end

  // Result register: load on fire, drop valid once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sample_out_q <= y;
      clipped_q    <= clip;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;
  assign out_o.clipped    = clipped_q;

endmodule

>>> rtl/iir_df1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR direct form I port checker
// Concurrent checks on the filter ports, bound to the top level.
// ----------------------------------------------------------------------------
module iir_df1_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input iir_df1_pkg::sample_t sample_out_i,
  input logic                 clipped_i
);
  import iir_df1_pkg::*;

  // no result is offered on the edge after a reset cycle
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(sample_out_i) && $stable(clipped_i))
    else $error("stalled result changed");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && clipped_i |->
      (sample_out_i == sample_t'(OutMax)) || (sample_out_i == sample_t'(OutMin)))
    else $error("clipped result not at full scale");

  // an accepted input sample with an empty output yields a result through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_i && !out_valid_i |-> ##2 out_valid_i)
    else $error("result missing two cycles after input");

endmodule

bind iir_filter_direct_form_one iir_df1_checker u_iir_df1_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_out_i (out_o.sample_out),
  .clipped_i    (out_o.clipped)
);
